[design/ic_pkg.sv]
// Shared types and constants for the inversion counter.
package ic_pkg;

    localparam int VALUE_W = 32;
    localparam int INV_W   = 11;
    localparam logic [INV_W-1:0] TOTAL_MAX = {INV_W{1'b1}};

    // Control and data of one element walking down the cell row.
    typedef struct packed {
        logic                      vld;   // beat present in this stage
        logic                      last;  // closes the sequence
        logic                      act;   // within capacity: compare and store
        logic                      ovf;   // a drop was seen in this sequence
        logic signed [VALUE_W-1:0] value;
    } t_tok;

endpackage

[design/ic_cell.sv]
// One cell of the row: holds one stored element and counts greater ones.
module ic_cell #(
    parameter int IDX_W    = 6,
    parameter int CNT_W    = 6,
    parameter int CELL_IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  ic_pkg::t_tok      i_tok,
    input  logic [IDX_W-1:0]  i_idx,
    input  logic [CNT_W-1:0]  i_cnt,
    output ic_pkg::t_tok      o_tok,
    output logic [IDX_W-1:0]  o_idx,
    output logic [CNT_W-1:0]  o_cnt
);
    import ic_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic signed [VALUE_W-1:0] r_stored;
    t_tok                      r_tok;
    logic [IDX_W-1:0]          r_idx;
    logic [CNT_W-1:0]          r_cnt;
    logic                      hit;
    logic                      wr;

    // Only entries below the element's own slot belong to earlier elements.
    assign hit = i_tok.vld && i_tok.act && (i_idx > MY_IDX) && (r_stored > i_tok.value);
    assign wr  = i_tok.vld && i_tok.act && (i_idx == MY_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else if (i_adv) begin
            r_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_idx <= i_idx;
            r_cnt <= i_cnt + CNT_W'(hit);
            if (wr) begin
                r_stored <= i_tok.value;
            end
        end
    end

    assign o_tok = r_tok;
    assign o_idx = r_idx;
    assign o_cnt = r_cnt;

endmodule

[design/inversion_counter_core.sv]
// Inversion counter top level: fill tracking, cell row, total and result register.
// Path: an accepted input beat loads the first cell, then moves through each further cell
//   and into the output register; only a beat with tlast produces a result.
// Throughput: one input beat per cycle; the row moves as one pipeline and holds
//   still only while a result waits in the output register.
// Reset: synchronous, active low; clears fill count, total, drop flag, stage valids.
module inversion_counter_core #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value (signed)
    input  logic        i_s_axis_tlast,   // last element of the sequence
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [10:0] inversions, [15:11] zero
    output logic        o_m_axis_tuser    // [0] overflow
);
    import ic_pkg::*;

    localparam int IDX_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W  = IDX_W;            // per-element count is at most MAX-1
    localparam int FILL_W = $clog2(MAX_ELEMENTS + 1);
    localparam int SUM_W  = ((INV_W > CNT_W) ? INV_W : CNT_W) + 1;
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(MAX_ELEMENTS);

    // whole row advances when the result register is free or being drained
    logic adv;
    logic acc;

    // input side: fill count and drop flag of the current sequence
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_drop, n_drop;
    logic              in_act;

    // cell row links
    t_tok             tok_c [0:MAX_ELEMENTS];
    logic [IDX_W-1:0] idx_c [0:MAX_ELEMENTS];
    logic [CNT_W-1:0] cnt_c [0:MAX_ELEMENTS];

    // tail
    logic [INV_W-1:0] r_total, n_total;
    logic [SUM_W-1:0] sum;
    logic [INV_W-1:0] sat;
    logic             r_out_valid;
    logic [INV_W-1:0] r_out_inv;
    logic             r_out_ovf;
    t_tok             tail;

    assign adv = !r_out_valid || i_m_axis_tready;
    assign acc = i_s_axis_tvalid && adv;
    assign o_s_axis_tready = adv;

    // An element arriving with the store full is neither compared nor stored.
    assign in_act = (r_fill != FILL_FULL);

    always_comb begin
        n_fill = r_fill;
        n_drop = r_drop;
        if (acc) begin
            if (i_s_axis_tlast) begin
                n_fill = '0;
                n_drop = 1'b0;
            end else begin
                n_fill = r_fill + FILL_W'(in_act);
                n_drop = r_drop || !in_act;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_drop <= 1'b0;
        end else begin
            r_fill <= n_fill;
            r_drop <= n_drop;
        end
    end

    // Head of the row: the element carries its slot number; the count starts at zero.
    always_comb begin
        tok_c[0].vld   = i_s_axis_tvalid;
        tok_c[0].last  = i_s_axis_tlast;
        tok_c[0].act   = in_act;
        tok_c[0].ovf   = r_drop || !in_act;
        tok_c[0].value = i_s_axis_tdata;
        idx_c[0]       = r_fill[IDX_W-1:0];
        cnt_c[0]       = '0;
    end

    // Each element passes every cell behind its predecessor, so the
    // predecessor has already written its slot when the element reaches it.
    for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
        ic_cell #(
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_tok   (tok_c[g]),
            .i_idx   (idx_c[g]),
            .i_cnt   (cnt_c[g]),
            .o_tok   (tok_c[g+1]),
            .o_idx   (idx_c[g+1]),
            .o_cnt   (cnt_c[g+1])
        );
    end

    assign tail = tok_c[MAX_ELEMENTS];

    // Running total, saturating at the top of the 11-bit range.
    assign sum = SUM_W'(r_total) + SUM_W'(cnt_c[MAX_ELEMENTS]);
    assign sat = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[INV_W-1:0];

    always_comb begin
        n_total = r_total;
        if (tail.vld && tail.act) begin
            n_total = sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= tail.vld && tail.last;
            if (tail.vld && tail.last) begin
                r_total <= '0;
            end else begin
                r_total <= n_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && tail.vld && tail.last) begin
            r_out_inv <= n_total;
            r_out_ovf <= tail.ovf;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(16-INV_W){1'b0}}, r_out_inv};
    assign o_m_axis_tuser  = r_out_ovf;

    // fill count never runs past capacity
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("fill count beyond capacity");

    // a closing beat restarts the fill count
    a_fill_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_s_axis_tlast) |=> (r_fill == '0))
        else $error("fill count not cleared after last beat");

    // a dropped element always carries the overflow mark to the tail
    a_drop_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tail.vld && !tail.act) |-> tail.ovf)
        else $error("dropped element without overflow mark");

    // a result appears only from a closing element at the tail
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(tail.vld && tail.last && adv))
        else $error("result without closing element");

endmodule

[test/inversion_counter_core_tb.sv]
// Self-checking testbench for the inversion counter core: random sequences, stalls, scoreboard.
`timescale 1ns / 1ps

module inversion_counter_core_tb;
    import ic_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int CLK_HALF     = 4;
    localparam int RAND_ITEMS   = 1350;
    localparam int MIN_RUNS     = 60;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int DRAIN_CYCLES = 4 * (CAPACITY + 1);

    typedef enum int {SHAPE_RANDOM, SHAPE_RISING, SHAPE_FALLING} t_run_shape;
    typedef enum int {VAL_FULL, VAL_NARROW, VAL_EDGE} t_value_mode;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        int unsigned               gap;    // idle cycles before this beat is offered
    } t_elem_beat;

    typedef struct {
        logic [INV_W-1:0] inversions;
        logic             overflow;
    } t_count_rec;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;

    inversion_counter_core #(
        .MAX_ELEMENTS(CAPACITY)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // [31:0] value (signed)
        .i_s_axis_tlast  (s_tlast),   // last element of the sequence
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // [10:0] inversions, [15:11] zero
        .o_m_axis_tuser  (m_tuser)    // [0] overflow
    );

    initial begin
        forever #CLK_HALF clk = ~clk;
    end

    t_elem_beat  pending_beats[$];
    t_count_rec  count_queue[$];
    int          errors = 0;

    // Shadow of the block's sequence state.
    logic signed [VALUE_W-1:0] seq_vals[CAPACITY];
    int unsigned               seq_fill    = 0;
    logic [INV_W-1:0]          seq_total   = '0;
    logic                      seq_dropped = 1'b0;

    function automatic void count_inversions(logic signed [VALUE_W-1:0] v, logic is_last);
        int unsigned above;
        int unsigned sum;
        t_count_rec  rec;
        if (seq_fill < CAPACITY) begin
            above = 0;
            for (int i = 0; i < seq_fill; i++) begin
                if (seq_vals[i] > v) above++;
            end
            sum = seq_total + above;
            seq_total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[INV_W-1:0];
            seq_vals[seq_fill] = v;
            seq_fill++;
        end else begin
            seq_dropped = 1'b1;
        end
        if (is_last) begin
            rec.inversions = seq_total;
            rec.overflow   = seq_dropped;
            count_queue = {count_queue, rec};
            seq_fill    = 0;
            seq_total   = '0;
            seq_dropped = 1'b0;
        end
    endfunction

    // Source side: offers queued beats, idles per beat, feeds the shadow model on accept.
    int unsigned tx_wait = 0;

    always @(posedge clk) begin : source_side
        t_elem_beat nxt;
        logic       slot_free;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            tx_wait  <= 0;
        end else begin
            slot_free = !s_tvalid;
            if (s_tvalid && s_tready) begin
                count_inversions(s_tdata, s_tlast);
                slot_free = 1'b1;
            end
            if (slot_free) begin
                if (pending_beats.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (tx_wait < pending_beats[0].gap) begin
                    tx_wait  <= tx_wait + 1;
                    s_tvalid <= 1'b0;
                end else begin
                    nxt = pending_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.value;
                    s_tlast  <= nxt.last;
                    tx_wait  <= 0;
                end
            end
        end
    end

    // Sink side: random backpressure, compares each result beat with the oldest count.
    int unsigned rx_hold  = 0;
    logic        rx_quiet = 1'b0;

    always @(posedge clk) begin : sink_side
        t_count_rec  want;
        int unsigned hold;
        if (!rst_n) begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (count_queue.size() == 0) begin
                    $display("%0t ERROR unexpected result: expected none, actual inv=%0d ovf=%0b",
                             $time, m_tdata[INV_W-1:0], m_tuser);
                    errors++;
                end else begin
                    want = count_queue.pop_front();
                    if (m_tdata[INV_W-1:0] !== want.inversions) begin
                        $display("%0t ERROR inversions: expected %0d, actual %0d",
                                 $time, want.inversions, m_tdata[INV_W-1:0]);
                        errors++;
                    end
                    if (m_tuser !== want.overflow) begin
                        $display("%0t ERROR overflow: expected %0b, actual %0b",
                                 $time, want.overflow, m_tuser);
                        errors++;
                    end
                    if (m_tdata[15:INV_W] !== '0) begin
                        $display("%0t ERROR tdata pad: expected 0, actual %0h",
                                 $time, m_tdata[15:INV_W]);
                        errors++;
                    end
                end
                if ($urandom_range(0, 7) == 0) rx_quiet = ~rx_quiet;
                hold = rx_quiet ? 0 : $urandom_range(0, 15);
                rx_hold  <= hold;
                m_tready <= (hold == 0);
            end else if (rx_hold != 0) begin
                rx_hold  <= rx_hold - 1;
                m_tready <= (rx_hold == 1);
            end else begin
                // occasional stall with nothing waiting, so gaps also hit mid-sequence
                hold = (!rx_quiet && $urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
                rx_hold  <= hold;
                m_tready <= (hold == 0);
            end
        end
    end

    function automatic logic signed [VALUE_W-1:0] pick_value(t_value_mode mode);
        logic signed [VALUE_W-1:0] v;
        case (mode)
            VAL_NARROW: begin
                v = $urandom_range(0, 6);
                v = v - 3;
            end
            VAL_EDGE: begin
                case ($urandom_range(0, 4))
                    0:       v = 32'sh8000_0000;
                    1:       v = 32'sh7FFF_FFFF;
                    2:       v = 0;
                    3:       v = -1;
                    default: v = 1;
                endcase
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    int n_items = 0;
    int n_runs  = 0;

    task automatic add_beat(logic signed [VALUE_W-1:0] v, logic is_last, int unsigned gap);
        t_elem_beat b;
        b.value = v;
        b.last  = is_last;
        b.gap   = gap;
        pending_beats = {pending_beats, b};
    endtask

    task automatic add_run(int len, t_run_shape shape, t_value_mode mode);
        logic signed [VALUE_W-1:0] v;
        logic                      quiet;
        quiet = ($urandom_range(0, 3) == 0);
        v = (shape == SHAPE_FALLING) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        for (int k = 0; k < len; k++) begin
            case (shape)
                SHAPE_RISING:  v = v + $urandom_range(1, 1 << 25);
                SHAPE_FALLING: v = v - $urandom_range(1, 1 << 25);
                default:       v = pick_value(mode);
            endcase
            add_beat(v, k == len - 1, quiet ? 0 : $urandom_range(0, 15));
        end
        n_items += len;
        n_runs++;
    endtask

    initial begin : stimulus
        int          len;
        t_run_shape  shape;
        t_value_mode mode;

        // directed: single elements at the extremes
        add_beat(32'sh8000_0000, 1'b1, 0);
        add_beat(32'sh7FFF_FFFF, 1'b1, 0);
        // max before min counts once, min before max not at all
        add_beat(32'sh7FFF_FFFF, 1'b0, 0);
        add_beat(32'sh8000_0000, 1'b1, 3);
        add_beat(32'sh8000_0000, 1'b0, 0);
        add_beat(32'sh7FFF_FFFF, 1'b1, 0);
        // equal values never count
        add_beat(7, 1'b0, 0);
        add_beat(7, 1'b0, 0);
        add_beat(7, 1'b1, 0);
        // sign handling around zero
        add_beat(-1, 1'b0, 0);
        add_beat(0, 1'b0, 1);
        add_beat(1, 1'b0, 0);
        add_beat(-1, 1'b1, 0);
        add_beat(1, 1'b0, 0);
        add_beat(0, 1'b0, 0);
        add_beat(-1, 1'b0, 2);
        add_beat(32'sh8000_0000, 1'b1, 0);

        // full row falling (largest total), then past capacity with the drop flag
        add_run(CAPACITY, SHAPE_FALLING, VAL_FULL);
        add_run(CAPACITY + 6, SHAPE_FALLING, VAL_FULL);

        while (n_items < RAND_ITEMS || n_runs < MIN_RUNS) begin
            case ($urandom_range(0, 3))
                0:       mode = VAL_NARROW;
                1:       mode = VAL_EDGE;
                default: mode = VAL_FULL;
            endcase
            case ($urandom_range(0, 9))
                0:       shape = SHAPE_RISING;
                1:       shape = SHAPE_FALLING;
                default: shape = SHAPE_RANDOM;
            endcase
            // mostly short runs; a few sit around the capacity boundary
            if ($urandom_range(0, 24) == 0) len = $urandom_range(CAPACITY - 1, CAPACITY + 4);
            else                            len = $urandom_range(1, 20);
            add_run(len, shape, mode);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_beats.size() != 0 || s_tvalid || count_queue.size() != 0)
            @(posedge clk);
        // catch any stray result beat still in the row
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("%0t ERROR timeout: %0d counts still expected", $time, count_queue.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
